[design/lpcr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the LPC residual filter.
// No dependencies; imported by lpcr_ctrl, lpcr_dp, the top level and the testbench.
package lpcr_pkg;

  localparam int TAPS_DEF  = 32;
  localparam int ORDER_W   = 6;
  localparam int IDX_W     = 5;
  localparam int COEF_W    = 24;
  localparam int SMP_W     = 16;
  localparam int RES_W     = 17;
  localparam int PROD_W    = COEF_W + SMP_W;
  localparam int FRAC_BITS = 20;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MAC,
    ST_FINISH
  } state_e;

  // How the prediction of the current sample is formed
  typedef enum logic [1:0] {
    MODE_SELF,
    MODE_LAST,
    MODE_FULL
  } mode_e;

  typedef struct packed {
    logic capture;
    logic coef_we;
    logic mac_clear;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic more;
    logic busy;
    logic out_free;
  } status_t;

endpackage

[design/lpcr_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/lpcr_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the LPC residual filter: request intake, MAC loop, finish.
// Depends on lpcr_pkg; drives the datapath through cmd_t, reads status_t.
module lpcr_ctrl
  import lpcr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    operation_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (operation_i == OP_LOAD) begin
            cmd_o.coef_we = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (status_i.full) begin
          cmd_o.mac_clear = 1'b1;
          state_d         = ST_MAC;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_MAC: begin
        cmd_o.issue = status_i.more;
        // drain the read/multiply stages before rounding
        if (!status_i.more && !status_i.busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[design/lpcr_dp.sv]
`timescale 1ns / 1ps
// Datapath of the LPC residual filter: coefficient and history RAMs,
// multiply-accumulate pipeline, saturation, rounding and output register.
// Depends on lpcr_pkg and lpcr_ram.
module lpcr_dp
  import lpcr_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output status_t                    status_o,
  input  logic                       cfg_we_i,
  input  logic [ORDER_W-1:0]         cfg_wdata_i,
  input  logic [IDX_W-1:0]           coef_index_i,
  input  logic signed [COEF_W-1:0]   coef_value_i,
  input  logic signed [SMP_W-1:0]    sample_i,
  input  logic                       restart_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SMP_W-1:0]    prediction_o,
  output logic signed [RES_W-1:0]    residual_o
);

  localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CW    = $clog2(TAPS + 1);
  localparam int NW    = $clog2(TAPS + 2);
  localparam int ACC_W = PROD_W + $clog2(TAPS) + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd34358689792);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd34359738368);
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(64'sd524288);

  logic [ORDER_W-1:0]       order_q;
  logic [CW-1:0]            taps;
  logic [TAPS-1:0]          cval_q;
  logic [NW-1:0]            cnt_q, cnt_eff;
  logic [AW-1:0]            wp_q, rp_q, rp_prev;
  logic [CW-1:0]            idx_q;
  logic signed [SMP_W-1:0]  smp_q, last_q;
  mode_e                    mode_q, mode_d;
  logic                     v1_q, v2_q, cv1_q;
  logic signed [COEF_W-1:0] coef_rd, coef_use;
  logic signed [SMP_W-1:0]  hist_rd;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_sat, acc_rnd;
  logic signed [SMP_W-1:0]  pred;
  logic                     coef_wr;
  logic                     out_valid_q;
  logic signed [SMP_W-1:0]  pred_q;
  logic signed [RES_W-1:0]  res_q;

  assign taps = (int'(order_q) > TAPS) ? CW'(TAPS) : CW'(order_q);
  assign cnt_eff = restart_i ? '0 : cnt_q;

  always_comb begin
    if (cnt_eff == '0) begin
      mode_d = MODE_SELF;
    end else if (int'(cnt_eff) <= int'(taps)) begin
      mode_d = MODE_LAST;
    end else begin
      mode_d = MODE_FULL;
    end
  end

  // step back one slot through the circular history
  function automatic logic [AW-1:0] dec_ptr(input logic [AW-1:0] p);
    dec_ptr = (p == '0) ? AW'(TAPS - 1) : p - AW'(1);
  endfunction

  assign rp_prev = dec_ptr(wp_q);
  assign coef_wr = cmd_i.coef_we && (int'(coef_index_i) < TAPS);

  lpcr_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_wr),
    .waddr_i (AW'(coef_index_i)),
    .wdata_i (coef_value_i),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (coef_rd)
  );

  lpcr_ram #(.WIDTH(SMP_W), .DEPTH(TAPS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.finish),
    .waddr_i (wp_q),
    .wdata_i (smp_q),
    .raddr_i (rp_q),
    .rdata_o (hist_rd)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= ORDER_W'(1);
      cval_q      <= '0;
      cnt_q       <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      idx_q       <= '0;
      mode_q      <= MODE_SELF;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (coef_wr) begin
        cval_q[AW'(coef_index_i)] <= 1'b1;
      end
      if (cmd_i.capture) begin
        cnt_q  <= cnt_eff;
        mode_q <= mode_d;
      end
      if (cmd_i.mac_clear) begin
        idx_q <= '0;
        rp_q  <= rp_prev;
      end else if (cmd_i.issue) begin
        idx_q <= idx_q + CW'(1);
        rp_q  <= dec_ptr(rp_q);
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.finish) begin
        if (int'(cnt_q) < TAPS + 1) begin
          cnt_q <= cnt_q + NW'(1);
        end
        wp_q <= (wp_q == AW'(TAPS - 1)) ? '0 : wp_q + AW'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // never-written coefficients read as zero
  assign coef_use = cv1_q ? coef_rd : '0;

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      smp_q <= sample_i;
    end
    cv1_q  <= cval_q[idx_q[AW-1:0]];
    prod_q <= coef_use * hist_rd;
    if (cmd_i.mac_clear) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
    if (cmd_i.finish) begin
      last_q <= smp_q;
      pred_q <= pred;
      res_q  <= {smp_q[SMP_W-1], smp_q} - {pred[SMP_W-1], pred};
    end
  end

  always_comb begin
    if (acc_q > SAT_HI) begin
      acc_sat = SAT_HI;
    end else if (acc_q < SAT_LO) begin
      acc_sat = SAT_LO;
    end else begin
      acc_sat = acc_q;
    end
    acc_rnd = acc_sat + HALF;
    case (mode_q)
      MODE_SELF: pred = smp_q;
      MODE_LAST: pred = last_q;
      MODE_FULL: pred = acc_rnd[FRAC_BITS+SMP_W-1:FRAC_BITS];
      default:   pred = smp_q;
    endcase
  end

  assign status_o.full     = (mode_q == MODE_FULL);
  assign status_o.more     = (idx_q < taps);
  assign status_o.busy     = v1_q || v2_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign prediction_o = pred_q;
  assign residual_o   = res_q;

endmodule

[design/lpc_residual_filter.sv]
`timescale 1ns / 1ps
// LPC residual filter top level: controller plus datapath.
// Depends on lpcr_pkg, lpcr_ctrl, lpcr_dp (and lpcr_ram below it).
// Use: requests arrive on the in channel (valid/ready). A load request writes
// one tap coefficient (Q3.20) and returns nothing. A sample request returns
// one prediction/residual pair on the out channel. One request is worked at
// a time; ready is high only while the sequencer is idle. A warm-up sample
// (first of a stream, or within the first order samples) goes from the
// decide step straight to the finish step. A fully predicted sample runs
// one multiply-accumulate per tap through a read / multiply / accumulate
// pipeline, which drains before the sum is saturated and rounded.
// The result sits in an output register, so the next request is taken while
// the receiver stalls; a second result holds in the finish step until the
// register frees. The user must write the order register through cfg_we_i
// only while idle; the block itself does not enforce it. Reset sets order
// to 1, marks all coefficients as zero and starts a new stream; no clearing
// pass is needed.
module lpc_residual_filter
  import lpcr_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ORDER_W-1:0]       cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     operation_i,
  input  logic [IDX_W-1:0]         coef_index_i,
  input  logic signed [COEF_W-1:0] coef_value_i,
  input  logic signed [SMP_W-1:0]  sample_i,
  input  logic                     restart_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [SMP_W-1:0]  prediction_o,
  output logic signed [RES_W-1:0]  residual_o
);

  cmd_t    cmd;
  status_t status;

  lpcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_ready_o  (in_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lpcr_dp #(.TAPS(TAPS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .sample_i     (sample_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .prediction_o (prediction_o),
    .residual_o   (residual_o)
  );

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for lpc_residual_filter: a directed table, then random
// coefficient loads and sample streams under several predictor orders.
// Depends on lpcr_pkg and the lpc_residual_filter RTL.
module testbench;
  import lpcr_pkg::*;

  localparam int HALF_NS     = 5;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE      = 48;   // long enough for a full-order sample to finish
  localparam int HOLD_LONG   = 400;
  localparam int PHASE_ITEMS = 175;
  localparam longint SUM_HI  = 64'sd32767 <<< FRAC_BITS;
  localparam longint SUM_LO  = -(64'sd32768 <<< FRAC_BITS);
  localparam longint HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic                     op;
    logic [IDX_W-1:0]         idx;
    logic signed [COEF_W-1:0] coef;
    logic signed [SMP_W-1:0]  smp;
    logic                     restart;
  } lpc_req_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] prediction;
    logic signed [RES_W-1:0] residual;
  } res_pair_t;

  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_ORDER
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    lpc_req_t           req;
    logic [ORDER_W-1:0] order_val;
    logic               fixed;
    res_pair_t          want;
  } dir_row_t;

  localparam int DIR_N = 27;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // first sample after reset predicts itself, then warm-up, then empty table
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, 16'sd1000, 1'b0}, 6'd0, 1'b1,
      '{16'sd1000, 17'sd0}},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, 16'sh8000, 1'b0}, 6'd0, 1'b1,
      '{16'sd1000, -17'sd33768}},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, 16'sh7FFF, 1'b0}, 6'd0, 1'b1,
      '{16'sd0, 17'sd32767}},
    // extreme coefficients drive the sum into both saturation limits
    '{ROW_REQ, '{OP_LOAD, 5'd0, 24'sh7FFFFF, 16'sd0, 1'b0}, 6'd0, 1'b0, '0},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, 16'sh7FFF, 1'b0}, 6'd0, 1'b1,
      '{16'sh7FFF, 17'sd0}},
    '{ROW_REQ, '{OP_LOAD, 5'd0, 24'sh800000, 16'sd0, 1'b0}, 6'd0, 1'b0, '0},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, 16'sh8000, 1'b0}, 6'd0, 1'b1,
      '{16'sh8000, 17'sd0}},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, 16'sh8000, 1'b0}, 6'd0, 1'b1,
      '{16'sh7FFF, -17'sd65535}},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, 16'sh7FFF, 1'b1}, 6'd0, 1'b1,
      '{16'sh7FFF, 17'sd0}},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, 16'sh7FFF, 1'b0}, 6'd0, 1'b1,
      '{16'sh7FFF, 17'sd0}},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, 16'sh7FFF, 1'b0}, 6'd0, 1'b1,
      '{16'sh8000, 17'sd65535}},
    // half weight: check rounding half up on both signs
    '{ROW_REQ, '{OP_LOAD, 5'd0, 24'sd524288, 16'sd0, 1'b0}, 6'd0, 1'b0, '0},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, 16'sd3, 1'b0}, 6'd0, 1'b1,
      '{16'sd16384, -17'sd16381}},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, -16'sd3, 1'b0}, 6'd0, 1'b1,
      '{16'sd2, -17'sd5}},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, 16'sd0, 1'b0}, 6'd0, 1'b1,
      '{-16'sd1, 17'sd1}},
    // loads ignore the sample fields
    '{ROW_REQ, '{OP_LOAD, 5'd31, 24'sh123456, 16'sh7FFF, 1'b1}, 6'd0, 1'b0, '0},
    '{ROW_REQ, '{OP_LOAD, 5'd5, -24'sd77777, 16'sh8000, 1'b1}, 6'd0, 1'b0, '0},
    '{ROW_ORDER, '0, 6'd0, 1'b0, '0},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, 16'sd500, 1'b1}, 6'd0, 1'b1,
      '{16'sd500, 17'sd0}},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, -16'sd700, 1'b0}, 6'd0, 1'b1,
      '{16'sd0, -17'sd700}},
    '{ROW_ORDER, '0, 6'd63, 1'b0, '0},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, 16'sd100, 1'b1}, 6'd0, 1'b1,
      '{16'sd100, 17'sd0}},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, 16'sd200, 1'b0}, 6'd0, 1'b0, '0},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, 16'sd300, 1'b0}, 6'd0, 1'b0, '0},
    '{ROW_ORDER, '0, 6'd32, 1'b0, '0},
    '{ROW_REQ, '{OP_SAMPLE, 5'd0, 24'sd0, -16'sd1, 1'b1}, 6'd0, 1'b0, '0},
    // sample requests ignore the coefficient fields
    '{ROW_REQ, '{OP_SAMPLE, 5'd31, 24'sh800000, 16'sd1, 1'b0}, 6'd0, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [ORDER_W-1:0] cfg_wdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic req_op, req_restart;
  logic [IDX_W-1:0] req_idx;
  logic signed [COEF_W-1:0] req_coef;
  logic signed [SMP_W-1:0] req_smp;
  logic signed [SMP_W-1:0] prediction;
  logic signed [RES_W-1:0] residual;

  // predictor state
  logic signed [COEF_W-1:0] coef_tbl [TAPS_DEF];
  logic signed [SMP_W-1:0] hist [TAPS_DEF];
  int stream_pos;
  logic [ORDER_W-1:0] order_reg;
  res_pair_t pending_pairs[$];

  int errors, sent_cnt, tx_pct, walk;

  always begin
    #HALF_NS clk = 1'b1;
    #HALF_NS clk = 1'b0;
  end

  lpc_residual_filter u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .operation_i (req_op),
    .coef_index_i(req_idx),
    .coef_value_i(req_coef),
    .sample_i    (req_smp),
    .restart_i   (req_restart),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .prediction_o(prediction),
    .residual_o  (residual)
  );

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 50;
    endcase
  endfunction

  // Apply one request to the predictor; returns 1 when it yields a result.
  function automatic bit lpc_predict(input lpc_req_t r, output res_pair_t pr);
    longint acc;
    int taps;
    int diff;
    logic signed [SMP_W-1:0] pv;
    pr = '0;
    if (r.op == OP_LOAD) begin
      coef_tbl[r.idx] = r.coef;
      return 1'b0;
    end
    if (r.restart) stream_pos = 0;
    taps = (order_reg > TAPS_DEF) ? TAPS_DEF : int'(order_reg);
    if (stream_pos == 0) begin
      pv = r.smp;
    end else if (stream_pos <= taps) begin
      pv = hist[0];
    end else begin
      acc = 0;
      for (int j = 0; j < taps; j++) acc += longint'(coef_tbl[j]) * longint'(hist[j]);
      if (acc > SUM_HI) acc = SUM_HI;
      else if (acc < SUM_LO) acc = SUM_LO;
      acc = (acc + HALF_LSB) >>> FRAC_BITS;
      pv = acc[SMP_W-1:0];
    end
    diff = int'(r.smp) - int'(pv);
    pr.prediction = pv;
    pr.residual = diff[RES_W-1:0];
    for (int j = TAPS_DEF - 1; j > 0; j--) hist[j] = hist[j-1];
    hist[0] = r.smp;
    if (stream_pos < TAPS_DEF + 1) stream_pos++;
    return 1'b1;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_pick(input int style);
    case (style)
      0: return COEF_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      1: return COEF_W'($urandom);
      default: return COEF_W'(int'($urandom_range(0, 1 << 15)) - (1 << 14));
    endcase
  endfunction

  function automatic lpc_req_t rand_req(input bit is_load, input bit restart, input int style);
    lpc_req_t r;
    r.op = is_load ? OP_LOAD : OP_SAMPLE;
    r.idx = IDX_W'($urandom_range(0, TAPS_DEF - 1));
    r.coef = is_load ? coef_pick(style) : COEF_W'($urandom);
    r.restart = is_load ? 1'($urandom) : restart;
    case ($urandom_range(0, 9))
      0: r.smp = SMP_W'($urandom);
      1: r.smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: begin
        walk += int'($urandom_range(0, 3000)) - 1500;
        if (walk > 32767) walk = 32767;
        else if (walk < -32768) walk = -32768;
        r.smp = walk[SMP_W-1:0];
      end
    endcase
    return r;
  endfunction

  task automatic send_req(input lpc_req_t r, input bit fixed, input res_pair_t want);
    res_pair_t pr;
    int gap;
    if (sent_cnt % 40 == 0) tx_pct = pick_pct();
    sent_cnt++;
    gap = (int'($urandom_range(0, 99)) < tx_pct) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_op      <= r.op;
    req_idx     <= r.idx;
    req_coef    <= r.coef;
    req_smp     <= r.smp;
    req_restart <= r.restart;
    do @(posedge clk); while (!in_ready);
    if (lpc_predict(r, pr)) pending_pairs.insert(pending_pairs.size(), fixed ? want : pr);
  endtask

  // Drain, let a trailing load finish, then write the order register.
  task automatic set_order(input logic [ORDER_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    order_reg = v;
  endtask

  task automatic run_phase(input logic [ORDER_W-1:0] ord);
    int style, left, len, taps;
    lpc_req_t r;
    set_order(ord);
    style = $urandom_range(0, 2);
    taps = (ord > TAPS_DEF) ? TAPS_DEF : int'(ord);
    for (int j = 0; j < TAPS_DEF; j++) begin
      r = rand_req(1'b1, 1'b0, style);
      r.idx = IDX_W'(j);
      if (style == 2 && j == 0) r.coef = 24'sh1E0000;
      if (style == 2 && j == 1) r.coef = -24'sh0E0000;
      send_req(r, 1'b0, '0);
    end
    left = PHASE_ITEMS;
    while (left > 0) begin
      // mostly streams that get past the warm-up, a few cut short
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4)
                                        : taps + 2 + $urandom_range(0, 40);
      for (int k = 0; k < len && left > 0; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_req(rand_req(1'b1, 1'b0, ($urandom_range(0, 3) == 0) ? 1 : style), 1'b0, '0);
          left--;
        end
        r = rand_req(1'b0, (k == 0) ? ($urandom_range(0, 7) != 0)
                                    : ($urandom_range(0, 49) == 0), style);
        send_req(r, 1'b0, '0);
        left--;
      end
    end
  endtask

  initial begin : main
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    req_op      = OP_LOAD;
    req_idx     = '0;
    req_coef    = '0;
    req_smp     = '0;
    req_restart = 1'b0;
    errors      = 0;
    sent_cnt    = 0;
    tx_pct      = 0;
    walk        = 0;
    order_reg   = 6'd1;
    stream_pos  = 0;
    for (int j = 0; j < TAPS_DEF; j++) begin
      coef_tbl[j] = '0;
      hist[j] = '0;
    end
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].kind == ROW_ORDER) set_order(DIR_TAB[i].order_val);
      else send_req(DIR_TAB[i].req, DIR_TAB[i].fixed, DIR_TAB[i].want);
    end
    run_phase(6'd1);
    run_phase(6'd0);
    run_phase(6'd32);
    run_phase(6'd63);
    run_phase(ORDER_W'($urandom_range(2, 31)));
    run_phase(ORDER_W'($urandom_range(33, 62)));
    run_phase(6'd2);
    run_phase(ORDER_W'($urandom_range(2, 31)));
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : receiver
    int stall_left, cyc, rx_pct, got;
    res_pair_t want;
    stall_left = 0;
    cyc = 0;
    rx_pct = 0;
    got = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got++;
        if (pending_pairs.size() == 0) begin
          $error("unexpected result: prediction %0d residual %0d", prediction, residual);
          errors++;
        end else begin
          want = pending_pairs.pop_front();
          if (prediction !== want.prediction) begin
            $error("prediction: expected %0d, got %0d", want.prediction, prediction);
            errors++;
          end
          if (residual !== want.residual) begin
            $error("residual: expected %0d, got %0d", want.residual, residual);
            errors++;
          end
        end
        // hold off long enough for the block to fill and stall its input
        if (got == 150 || got == 900) stall_left = HOLD_LONG;
      end
      cyc++;
      if (cyc % 300 == 0) rx_pct = pick_pct();
      if (stall_left == 0 && int'($urandom_range(0, 99)) < rx_pct) stall_left = gap_len();
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle = 0;
      else idle++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[lpc_residual_filter.f]
design/lpcr_pkg.sv
design/lpcr_ram.sv
design/lpcr_ctrl.sv
design/lpcr_dp.sv
design/lpc_residual_filter.sv
dv/testbench.sv
